[sv/tfp_pkg.sv]
// Shared types and constants for the telemetry frame parser.
// Used by the result interface, the byte parser, the serial arithmetic units and the top level.
package tfp_pkg;

  localparam int KIND_W = 3;
  localparam int SLOT_W = 6;
  localparam int RES_W = 42;
  localparam int WIDE_W = 33;
  localparam int PROD_W = 43;
  localparam int MULT_W = 10;

  localparam logic [KIND_W-1:0] KIND_MEAS = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RUN = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RATIO = 3'd2;
  localparam logic [KIND_W-1:0] KIND_UNDEF = 3'd3;
  localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd4;

  localparam logic [SLOT_W-1:0] SLOT_NONE = 6'd0;
  localparam logic [SLOT_W-1:0] SLOT_RATIO = 6'd2;
  localparam logic [SLOT_W-1:0] SLOT_LAST = 6'd38;

  localparam logic [MULT_W-1:0] MULT_ONE = 10'd1;
  localparam logic [MULT_W-1:0] MULT_HUNDRED = 10'd100;
  localparam logic [MULT_W-1:0] MULT_THOUSAND = 10'd1000;

  localparam logic [1:0] FM_IGNORED = 2'd0;
  localparam logic [1:0] FM_DEFAULT = 2'd1;
  localparam logic [1:0] FM_RATIO = 2'd2;

  localparam logic signed [RES_W-1:0] RES_MAX = 42'sh1FF_FFFF_FFFF;
  localparam logic signed [RES_W-1:0] RES_MIN = 42'sh200_0000_0000;
  localparam logic signed [RES_W-1:0] RATIO_DEFAULT = 42'sd1000;

  typedef struct packed {
    logic                     rec_valid;
    logic [KIND_W-1:0]        rec_kind;
    logic [SLOT_W-1:0]        rec_slot;
    logic [MULT_W-1:0]        rec_mult;
    logic signed [WIDE_W-1:0] rec_value;
    logic                     frame_end;
    logic [1:0]               frame_mode;
    logic signed [WIDE_W-1:0] fwd;
    logic signed [WIDE_W-1:0] rfl;
  } tfp_event_t;

endpackage

[sv/tfp_in_if.sv]
// Byte channel of the telemetry frame parser.
// Carries one frame byte and its end-of-frame mark per request.
interface tfp_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink (input valid, input data_byte, input frame_last, output ready);
endinterface

[sv/tfp_out_if.sv]
// Result channel of the telemetry frame parser.
// Depends on tfp_pkg for the field widths.
interface tfp_out_if import tfp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [SLOT_W-1:0]       slot;
  logic signed [RES_W-1:0] value;
  logic                    last;

  modport source (output valid, output kind, output slot, output value, output last,
                  input ready);
  modport sink (input valid, input kind, input slot, input value, input last,
                output ready);
endinterface

[sv/tfp_parser.sv]
// Byte-level frame parser: header check, body length, record splitting and decoding.
// The value register takes one byte digit per accepted byte. Depends on tfp_pkg.
module tfp_parser import tfp_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       frame_last,
  output tfp_event_t ev
);

  localparam logic [2:0] PH_TYPE_HI = 3'd0;
  localparam logic [2:0] PH_TYPE_LO = 3'd1;
  localparam logic [2:0] PH_LEN_HI = 3'd2;
  localparam logic [2:0] PH_LEN_LO = 3'd3;
  localparam logic [2:0] PH_VALUE = 3'd4;

  localparam logic [16:0] POS_MAX = 17'h1FFFF;

  localparam logic [15:0] T_RUN = 16'h0041;
  localparam logic [15:0] T_FIRST = 16'h0501;
  localparam logic [15:0] T_BLOCK_END = 16'h0520;
  localparam logic [15:0] T_FWD = 16'h0521;
  localparam logic [15:0] T_RFL = 16'h0522;
  localparam logic [15:0] T_TENTHS = 16'h0523;
  localparam logic [15:0] T_TENTHS_END = 16'h0525;
  localparam logic [15:0] T_LAST = 16'h0526;

  logic [16:0]           byte_position, byte_position_next;
  logic [15:0]           declared_length, declared_length_next;
  logic                  header_good, header_good_next;
  logic [2:0]            phase, phase_next;
  logic [15:0]           record_type, record_type_next;
  logic [7:0]            length_hi, length_hi_next;
  logic [15:0]           bytes_left, bytes_left_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic [VALUE_BITS-1:0] forward_raw, forward_raw_next;
  logic                  forward_seen, forward_seen_next;
  logic [VALUE_BITS-1:0] reflected_raw, reflected_raw_next;
  logic                  reflected_seen, reflected_seen_next;

  logic                     fire;
  logic [15:0]              full_length;
  logic [15:0]              left_dec;
  logic [VALUE_BITS+7:0]    acc_shift;
  logic signed [WIDE_W-1:0] v_ext;
  logic [15:0]              slot_block;
  logic [15:0]              slot_tenths;

  assign full_length = {length_hi, data_byte};
  assign left_dec = bytes_left - 16'd1;
  assign acc_shift = {acc, data_byte};
  assign slot_block = record_type - T_FIRST + 16'd3;
  assign slot_tenths = record_type - T_TENTHS + 16'd35;

  always_comb begin
    byte_position_next = byte_position;
    declared_length_next = declared_length;
    header_good_next = header_good;
    phase_next = phase;
    record_type_next = record_type;
    length_hi_next = length_hi;
    bytes_left_next = bytes_left;
    acc_next = acc;
    fire = 1'b0;
    if (byte_position <= 17'd2) begin
      if (data_byte != ((byte_position == 17'd0) ? 8'h01 : 8'h03)) begin
        header_good_next = 1'b0;
      end
    end else if (byte_position == 17'd3) begin
      declared_length_next = {data_byte, 8'h00};
    end else if (byte_position == 17'd4) begin
      declared_length_next = {declared_length[15:8], data_byte};
    end else if (header_good) begin
      case (phase)
        PH_TYPE_LO: begin
          record_type_next = {record_type[15:8], data_byte};
          phase_next = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          length_hi_next = data_byte;
          phase_next = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          acc_next = '0;
          bytes_left_next = full_length;
          if (full_length == 16'd0) begin
            fire = 1'b1;
            phase_next = PH_TYPE_HI;
          end else begin
            phase_next = PH_VALUE;
          end
        end
        PH_VALUE: begin
          acc_next = acc_shift[VALUE_BITS-1:0];
          bytes_left_next = left_dec;
          if (left_dec == 16'd0) begin
            fire = 1'b1;
            phase_next = PH_TYPE_HI;
          end
        end
        default: begin
          if (byte_position <= {1'b0, declared_length} + 17'd4) begin
            record_type_next = {data_byte, 8'h00};
            phase_next = PH_TYPE_LO;
          end else begin
            phase_next = PH_TYPE_HI;
          end
        end
      endcase
    end
    if (byte_position < POS_MAX) begin
      byte_position_next = byte_position + 17'd1;
    end
  end

  assign v_ext = {{(WIDE_W - VALUE_BITS){acc_next[VALUE_BITS-1]}}, acc_next};

  always_comb begin
    forward_raw_next = forward_raw;
    forward_seen_next = forward_seen;
    reflected_raw_next = reflected_raw;
    reflected_seen_next = reflected_seen;
    ev = '0;
    ev.rec_value = v_ext;
    ev.rec_mult = MULT_THOUSAND;
    ev.rec_kind = KIND_MEAS;
    ev.rec_slot = SLOT_NONE;
    if (fire) begin
      if (record_type == T_RUN) begin
        ev.rec_valid = 1'b1;
        ev.rec_kind = KIND_RUN;
        ev.rec_mult = MULT_ONE;
        ev.rec_value = (v_ext == 33'sd1) ? 33'sd0 : 33'sd1;
      end else if (record_type == T_FWD) begin
        ev.rec_valid = 1'b1;
        ev.rec_mult = MULT_ONE;
        forward_raw_next = acc_next;
        forward_seen_next = 1'b1;
      end else if (record_type == T_RFL) begin
        ev.rec_valid = 1'b1;
        ev.rec_slot = 6'd1;
        reflected_raw_next = acc_next;
        reflected_seen_next = 1'b1;
      end else if (record_type >= T_FIRST && record_type <= T_BLOCK_END) begin
        ev.rec_valid = 1'b1;
        ev.rec_slot = slot_block[SLOT_W-1:0];
      end else if (record_type >= T_TENTHS && record_type <= T_TENTHS_END) begin
        ev.rec_valid = 1'b1;
        ev.rec_slot = slot_tenths[SLOT_W-1:0];
        ev.rec_mult = MULT_HUNDRED;
      end else if (record_type == T_LAST) begin
        ev.rec_valid = 1'b1;
        ev.rec_slot = SLOT_LAST;
      end
    end
    ev.frame_end = frame_last;
    if (header_good_next && byte_position >= 17'd4) begin
      ev.frame_mode = (forward_seen_next && reflected_seen_next) ? FM_RATIO : FM_DEFAULT;
    end else begin
      ev.frame_mode = FM_IGNORED;
    end
    ev.fwd = {{(WIDE_W - VALUE_BITS){forward_raw_next[VALUE_BITS-1]}}, forward_raw_next};
    ev.rfl = {{(WIDE_W - VALUE_BITS){reflected_raw_next[VALUE_BITS-1]}},
              reflected_raw_next};
  end

  always_ff @(posedge clk) begin
    if (rst || (take && frame_last)) begin
      byte_position <= '0;
      declared_length <= '0;
      header_good <= 1'b1;
      phase <= PH_TYPE_HI;
      record_type <= '0;
      length_hi <= '0;
      bytes_left <= '0;
      acc <= '0;
      forward_raw <= '0;
      forward_seen <= 1'b0;
      reflected_raw <= '0;
      reflected_seen <= 1'b0;
    end else if (take) begin
      byte_position <= byte_position_next;
      declared_length <= declared_length_next;
      header_good <= header_good_next;
      phase <= phase_next;
      record_type <= record_type_next;
      length_hi <= length_hi_next;
      bytes_left <= bytes_left_next;
      acc <= acc_next;
      forward_raw <= forward_raw_next;
      forward_seen <= forward_seen_next;
      reflected_raw <= reflected_raw_next;
      reflected_seen <= reflected_seen_next;
    end
  end

endmodule

[sv/tfp_mul.sv]
// Bit-serial multiplier: a signed operand times a small unsigned constant factor.
// One factor bit per cycle, shift and add. Depends on tfp_pkg.
module tfp_mul import tfp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [WIDE_W-1:0]  a,
  input  logic [MULT_W-1:0]         m,
  output logic                      done,
  output logic signed [PROD_W-1:0]  prod
);

  logic [PROD_W-1:0] mcand;
  logic [MULT_W-1:0] mplier;
  logic [PROD_W-1:0] acc;
  logic [3:0]        cnt;
  logic              busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt <= 4'(MULT_W);
    end else begin
      done <= busy && (cnt == 4'd1);
      if (busy) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= {{(PROD_W - WIDE_W){a[WIDE_W-1]}}, a};
      mplier <= m;
      acc <= '0;
    end else if (busy) begin
      acc <= acc + (mplier[0] ? mcand : '0);
      mcand <= {mcand[PROD_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[MULT_W-1:1]};
    end
  end

  assign prod = $signed(acc);

endmodule

[sv/tfp_div.sv]
// Bit-serial restoring divider with truncation toward zero and 42-bit saturation.
// One quotient bit per cycle. Depends on tfp_pkg.
module tfp_div import tfp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [PROD_W-1:0] num,
  input  logic signed [WIDE_W-1:0] den,
  output logic                     done,
  output logic signed [RES_W-1:0]  quo
);

  logic [PROD_W-1:0] num_abs;
  logic [WIDE_W-1:0] den_abs;
  logic [RES_W-1:0]  shreg;
  logic [WIDE_W-1:0] divisor;
  logic [WIDE_W-1:0] rem;
  logic [WIDE_W:0]   trial;
  logic              neg;
  logic [5:0]        cnt;
  logic              busy;

  assign num_abs = num[PROD_W-1] ? -num : num;
  assign den_abs = den[WIDE_W-1] ? -den : den;
  assign trial = {rem, shreg[RES_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt <= 6'(RES_W);
    end else begin
      done <= busy && (cnt == 6'd1);
      if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= num_abs[RES_W-1:0];
      divisor <= den_abs;
      rem <= '0;
      neg <= num[PROD_W-1] ^ den[WIDE_W-1];
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        rem <= WIDE_W'(trial - {1'b0, divisor});
        shreg <= {shreg[RES_W-2:0], 1'b1};
      end else begin
        rem <= trial[WIDE_W-1:0];
        shreg <= {shreg[RES_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (!neg) begin
      quo = shreg[RES_W-1] ? RES_MAX : $signed(shreg);
    end else if (shreg[RES_W-1] && (|shreg[RES_W-2:0])) begin
      quo = RES_MIN;
    end else begin
      quo = -$signed(shreg);
    end
  end

endmodule

[sv/tlv_telemetry_frame_parser.sv]
// A byte that yields no result is taken every cycle while no result is pending. A byte
// that ends a record has its result made in the serial multiplier, and the next byte is
// taken once that result moves to the output register. A frame end gives its result from
// the frame state, or after 10 multiply and 42 divide steps when the ratio is needed; a
// byte with both results gives the record result first; output stalls hold off bytes.
// Synchronous reset returns all frame state to its start values; no clearing pass needed.
module tlv_telemetry_frame_parser import tfp_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input logic        clk,
  input logic        rst,
  tfp_in_if.sink     byte_ch,
  tfp_out_if.source  result_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REC_START = 3'd1;
  localparam logic [2:0] S_REC_MUL = 3'd2;
  localparam logic [2:0] S_FRAME = 3'd3;
  localparam logic [2:0] S_RAT_MUL = 3'd4;
  localparam logic [2:0] S_RAT_DIV = 3'd5;
  localparam logic [2:0] S_PUT = 3'd6;

  logic [2:0] state;
  logic       take;
  tfp_event_t ev, ev_q;

  logic                     mul_start, mul_done;
  logic signed [WIDE_W-1:0] mul_a;
  logic [MULT_W-1:0]        mul_m;
  logic signed [PROD_W-1:0] mul_prod;
  logic                     div_start, div_done;
  logic signed [RES_W-1:0]  div_quo;
  logic signed [WIDE_W-1:0] pw_sum, pw_diff;

  logic [KIND_W-1:0]       res_kind;
  logic [SLOT_W-1:0]       res_slot;
  logic signed [RES_W-1:0] res_value;
  logic                    res_last;

  logic                    out_valid;
  logic [KIND_W-1:0]       out_kind;
  logic [SLOT_W-1:0]       out_slot;
  logic signed [RES_W-1:0] out_value;
  logic                    out_last;
  logic                    out_free;

  assign byte_ch.ready = (state == S_IDLE);
  assign take = byte_ch.valid && byte_ch.ready;
  assign out_free = !out_valid || result_ch.ready;

  tfp_parser #(.VALUE_BITS(VALUE_BITS)) u_parser (
    .clk(clk),
    .rst(rst),
    .take(take),
    .data_byte(byte_ch.data_byte),
    .frame_last(byte_ch.frame_last),
    .ev(ev)
  );

  assign pw_sum = ev_q.fwd + ev_q.rfl;
  assign pw_diff = ev_q.fwd - ev_q.rfl;

  assign mul_start = (state == S_REC_START) ||
                     (state == S_FRAME && ev_q.frame_mode == FM_RATIO && pw_diff != '0);
  assign mul_a = (state == S_REC_START) ? ev_q.rec_value : pw_sum;
  assign mul_m = (state == S_REC_START) ? ev_q.rec_mult : MULT_THOUSAND;
  assign div_start = (state == S_RAT_MUL) && mul_done;

  tfp_mul u_mul (
    .clk(clk),
    .rst(rst),
    .start(mul_start),
    .a(mul_a),
    .m(mul_m),
    .done(mul_done),
    .prod(mul_prod)
  );

  tfp_div u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .num(mul_prod),
    .den(pw_diff),
    .done(div_done),
    .quo(div_quo)
  );

  always_ff @(posedge clk) begin
    if (take) begin
      ev_q <= ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            if (ev.rec_valid) begin
              state <= S_REC_START;
            end else if (ev.frame_end) begin
              state <= S_FRAME;
            end
          end
        end
        S_REC_START: begin
          state <= S_REC_MUL;
        end
        S_REC_MUL: begin
          if (mul_done) begin
            res_kind <= ev_q.rec_kind;
            res_slot <= ev_q.rec_slot;
            res_value <= mul_prod[RES_W-1:0];
            res_last <= !ev_q.frame_end;
            state <= S_PUT;
          end
        end
        S_FRAME: begin
          res_last <= 1'b1;
          if (ev_q.frame_mode == FM_IGNORED) begin
            res_kind <= KIND_IGNORED;
            res_slot <= SLOT_NONE;
            res_value <= '0;
            state <= S_PUT;
          end else if (ev_q.frame_mode == FM_DEFAULT) begin
            res_kind <= KIND_RATIO;
            res_slot <= SLOT_RATIO;
            res_value <= RATIO_DEFAULT;
            state <= S_PUT;
          end else if (pw_diff == '0) begin
            res_kind <= KIND_UNDEF;
            res_slot <= SLOT_RATIO;
            res_value <= '0;
            state <= S_PUT;
          end else begin
            state <= S_RAT_MUL;
          end
        end
        S_RAT_MUL: begin
          if (mul_done) begin
            state <= S_RAT_DIV;
          end
        end
        S_RAT_DIV: begin
          if (div_done) begin
            res_kind <= KIND_RATIO;
            res_slot <= SLOT_RATIO;
            res_value <= div_quo;
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (out_free) begin
            state <= res_last ? S_IDLE : S_FRAME;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_PUT && out_free) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUT && out_free) begin
      out_kind <= res_kind;
      out_slot <= res_slot;
      out_value <= res_value;
      out_last <= res_last;
    end
  end

  assign result_ch.valid = out_valid;
  assign result_ch.kind = out_kind;
  assign result_ch.slot = out_slot;
  assign result_ch.value = out_value;
  assign result_ch.last = out_last;

  a_mul_done_expected: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_REC_MUL || state == S_RAT_MUL))
    else $error("multiplier finished outside a multiply state");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_RAT_DIV))
    else $error("divider finished outside the divide state");

  a_frame_result_last: assert property (@(posedge clk) disable iff (rst)
    (result_ch.valid && (result_ch.kind == KIND_RATIO || result_ch.kind == KIND_UNDEF ||
     result_ch.kind == KIND_IGNORED)) |-> result_ch.last)
    else $error("frame-end result without last mark");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid |-> (result_ch.slot <= SLOT_LAST))
    else $error("slot index out of range");

  a_put_loads_output: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT && out_free) |=> (result_ch.valid && state != S_PUT))
    else $error("pending result not moved to the output register");

endmodule
